[rtl/blt_pkg.sv]
// ----------------------------------------------------------------------------
// blt_pkg
// Shared widths, codes and the command word type of the line stepper.
// ----------------------------------------------------------------------------
package blt_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRAME_BITS    = 13;
    localparam int MAX_FRAME_DIM = 4096;
    localparam int DIM_BITS      = $clog2(MAX_FRAME_DIM);
    localparam int ADDR_BITS     = 24;
    localparam int COLOR_BITS    = 8;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    // Command codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // Register indexes
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic                          func;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
        logic        [COLOR_BITS-1:0]  in_red;
        logic        [COLOR_BITS-1:0]  in_green;
        logic        [COLOR_BITS-1:0]  in_blue;
    } cmd_t;

endpackage

[rtl/blt_if.sv]
// ----------------------------------------------------------------------------
// blt_if
// Valid/ready channels of the line stepper: command words in, pixel words out.
// ----------------------------------------------------------------------------
interface blt_cmd_if;
    import blt_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic        [COLOR_BITS-1:0] in_red;
    logic        [COLOR_BITS-1:0] in_green;
    logic        [COLOR_BITS-1:0] in_blue;

    modport source (
        output valid, func, start_x, start_y, end_x, end_y, in_red, in_green, in_blue,
        input  ready
    );
    modport sink (
        input  valid, func, start_x, start_y, end_x, end_y, in_red, in_green, in_blue,
        output ready
    );
endinterface

interface blt_pixel_if;
    import blt_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic        [ADDR_BITS-1:0]  pixel_address;
    logic        [COLOR_BITS-1:0] out_red;
    logic        [COLOR_BITS-1:0] out_green;
    logic        [COLOR_BITS-1:0] out_blue;
    logic                         write_enable;
    logic                         line_done;

    modport source (
        output valid, pixel_x, pixel_y, pixel_address, out_red, out_green, out_blue,
               write_enable, line_done,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_address, out_red, out_green, out_blue,
               write_enable, line_done,
        output ready
    );
endinterface

[rtl/bresenham_line_stepper_top.sv]
// ----------------------------------------------------------------------------
// bresenham_line_stepper_top
// All-octant Bresenham line engine with frame clipping and address output.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          word
//  cmd      in   valid/ready        load (endpoints, colour) or step
//  pixel    out  valid/ready        x, y, address, colour, write enable, done
//  apb      in   psel/penable/pready frame_width at 0x0, frame_height at 0x4
//
//  A command word is registered, then handled against the line state; a step
//  writes the pixel word register. One word per clock while no step waits.
//  An accepted step is held in the command register, then written to the
//  pixel word register, where its pixel word waits until it is taken.
//  A load never waits on the pixel side; a step waits while the pixel
//  register is full and not taken. Reset clears the line state (no line).
// ----------------------------------------------------------------------------
module bresenham_line_stepper_top
    import blt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    blt_cmd_if.sink                  cmd,
    blt_pixel_if.source              pixel,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int DX_BITS  = COORD_BITS + 1;
    localparam int NDY_BITS = COORD_BITS + 2;
    localparam int ERR_BITS = COORD_BITS + 3;
    localparam int PROD_BITS = DIM_BITS + FRAME_BITS;

    // Configuration
    logic [FRAME_BITS-1:0] frame_width_reg;
    logic [FRAME_BITS-1:0] frame_height_reg;
    logic [FRAME_BITS-1:0] wr_value;
    logic                  apb_write;

    // Command stage
    logic cmd_valid_reg;
    cmd_t cmd_reg;
    cmd_t cmd_in;
    logic cmd_is_step;
    logic pixel_free;
    logic cmd_fire;
    logic step_fire;

    // Line state
    logic signed [COORD_BITS-1:0] cur_x_reg;
    logic signed [COORD_BITS-1:0] cur_y_reg;
    logic signed [COORD_BITS-1:0] target_x_reg;
    logic signed [COORD_BITS-1:0] target_y_reg;
    logic        [DX_BITS-1:0]    delta_x_reg;
    logic signed [NDY_BITS-1:0]   neg_delta_y_reg;
    logic                         step_x_neg_reg;
    logic                         step_y_neg_reg;
    logic signed [ERR_BITS-1:0]   error_term_reg;
    logic        [3*COLOR_BITS-1:0] line_color_reg;
    logic                         line_active_reg;

    // Load set-up
    logic signed [DX_BITS-1:0]    diff_x;
    logic signed [DX_BITS-1:0]    diff_y;
    logic        [DX_BITS-1:0]    load_dx;
    logic signed [NDY_BITS-1:0]   load_ndy;
    logic signed [ERR_BITS-1:0]   load_err;

    // Step
    logic signed [ERR_BITS:0]     doubled;
    logic                         take_x;
    logic                         take_y;
    logic signed [ERR_BITS-1:0]   err_next;
    logic signed [COORD_BITS-1:0] cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_next;
    logic                         in_frame;
    logic                         at_end;
    logic [PROD_BITS-1:0]         addr_prod;
    logic [PROD_BITS:0]           addr_sum;

    // Pixel register
    logic                         pix_valid_reg;
    logic signed [COORD_BITS-1:0] pix_x_reg;
    logic signed [COORD_BITS-1:0] pix_y_reg;
    logic [ADDR_BITS-1:0]         pix_addr_reg;
    logic [3*COLOR_BITS-1:0]      pix_color_reg;
    logic                         pix_we_reg;
    logic                         pix_done_reg;

    // ------------------------------------------------------------------
    // APB configuration
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;

    // Clamp the low FRAME_BITS of pwdata to MAX_FRAME_DIM
    always_comb
    begin
        wr_value = pwdata[FRAME_BITS-1:0];
        if (wr_value > FRAME_BITS'(MAX_FRAME_DIM))
        begin
            wr_value = FRAME_BITS'(MAX_FRAME_DIM);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_BITS'(640);
            frame_height_reg <= FRAME_BITS'(480);
        end
        else if (apb_write)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_FRAME_WIDTH:  frame_width_reg  <= wr_value;
                REG_FRAME_HEIGHT: frame_height_reg <= wr_value;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Command stage
    // ------------------------------------------------------------------
    assign cmd_in.func     = cmd.func;
    assign cmd_in.start_x  = cmd.start_x;
    assign cmd_in.start_y  = cmd.start_y;
    assign cmd_in.end_x    = cmd.end_x;
    assign cmd_in.end_y    = cmd.end_y;
    assign cmd_in.in_red   = cmd.in_red;
    assign cmd_in.in_green = cmd.in_green;
    assign cmd_in.in_blue  = cmd.in_blue;

    assign cmd_is_step = (cmd_reg.func == FUNC_STEP);
    assign pixel_free  = !pix_valid_reg || pixel.ready;
    // Loads never wait; steps hold until the pixel register can take a word
    assign cmd_fire    = cmd_valid_reg && (!cmd_is_step || pixel_free);
    assign step_fire   = cmd_fire && cmd_is_step;
    assign cmd.ready   = !cmd_valid_reg || cmd_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd.valid && cmd.ready)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (cmd_fire)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg <= cmd_in;
        end
    end

    // ------------------------------------------------------------------
    // Load set-up: directions, deltas and initial error
    // ------------------------------------------------------------------
    always_comb
    begin
        diff_x   = DX_BITS'(cmd_reg.end_x) - DX_BITS'(cmd_reg.start_x);
        diff_y   = DX_BITS'(cmd_reg.end_y) - DX_BITS'(cmd_reg.start_y);
        load_dx  = (diff_x < 0) ? DX_BITS'(-diff_x) : DX_BITS'(diff_x);
        load_ndy = (diff_y > 0) ? -NDY_BITS'(diff_y) : NDY_BITS'(diff_y);
        load_err = ERR_BITS'(signed'({1'b0, load_dx})) + ERR_BITS'(load_ndy);
    end

    // ------------------------------------------------------------------
    // Step: clip, end test, address and error advance
    // ------------------------------------------------------------------
    always_comb
    begin
        doubled = {error_term_reg, 1'b0};
        take_x  = doubled >= (ERR_BITS + 1)'(neg_delta_y_reg);
        take_y  = doubled <= signed'((ERR_BITS + 1)'(delta_x_reg));
        err_next = error_term_reg
                 + (take_x ? ERR_BITS'(neg_delta_y_reg) : ERR_BITS'(0))
                 + (take_y ? signed'(ERR_BITS'(delta_x_reg)) : ERR_BITS'(0));
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        if (take_x)
        begin
            cur_x_next = step_x_neg_reg ? cur_x_reg - COORD_BITS'(1)
                                        : cur_x_reg + COORD_BITS'(1);
        end
        if (take_y)
        begin
            cur_y_next = step_y_neg_reg ? cur_y_reg - COORD_BITS'(1)
                                        : cur_y_reg + COORD_BITS'(1);
        end

        in_frame = !cur_x_reg[COORD_BITS-1] && !cur_y_reg[COORD_BITS-1]
                && (unsigned'(cur_x_reg) < COORD_BITS'(frame_width_reg))
                && (unsigned'(cur_y_reg) < COORD_BITS'(frame_height_reg));
        at_end = (cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg);

        // Inside the frame both coordinates fit the dimension width
        addr_prod = PROD_BITS'(cur_y_reg[DIM_BITS-1:0]) * PROD_BITS'(frame_width_reg);
        addr_sum  = (PROD_BITS + 1)'(addr_prod)
                  + (PROD_BITS + 1)'(cur_x_reg[DIM_BITS-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            delta_x_reg     <= '0;
            neg_delta_y_reg <= '0;
            step_x_neg_reg  <= 1'b0;
            step_y_neg_reg  <= 1'b0;
            error_term_reg  <= '0;
            line_color_reg  <= '0;
            line_active_reg <= 1'b0;
        end
        else if (cmd_fire)
        begin
            if (!cmd_is_step)
            begin
                cur_x_reg       <= cmd_reg.start_x;
                cur_y_reg       <= cmd_reg.start_y;
                target_x_reg    <= cmd_reg.end_x;
                target_y_reg    <= cmd_reg.end_y;
                delta_x_reg     <= load_dx;
                neg_delta_y_reg <= load_ndy;
                step_x_neg_reg  <= !(diff_x > 0);
                step_y_neg_reg  <= !(diff_y > 0);
                error_term_reg  <= load_err;
                line_color_reg  <= {cmd_reg.in_red, cmd_reg.in_green, cmd_reg.in_blue};
                line_active_reg <= 1'b1;
            end
            else if (line_active_reg)
            begin
                if (at_end)
                begin
                    line_active_reg <= 1'b0;
                end
                else
                begin
                    cur_x_reg      <= cur_x_next;
                    cur_y_reg      <= cur_y_next;
                    error_term_reg <= err_next;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel word register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            pix_valid_reg <= 1'b1;
        end
        else if (pixel.ready)
        begin
            pix_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            if (line_active_reg)
            begin
                pix_x_reg     <= cur_x_reg;
                pix_y_reg     <= cur_y_reg;
                pix_addr_reg  <= in_frame ? addr_sum[ADDR_BITS-1:0] : '0;
                pix_color_reg <= line_color_reg;
                pix_we_reg    <= in_frame;
                pix_done_reg  <= at_end;
            end
            else
            begin
                // No line: report done, write nothing
                pix_x_reg     <= '0;
                pix_y_reg     <= '0;
                pix_addr_reg  <= '0;
                pix_color_reg <= '0;
                pix_we_reg    <= 1'b0;
                pix_done_reg  <= 1'b1;
            end
        end
    end

    assign pixel.valid         = pix_valid_reg;
    assign pixel.pixel_x       = pix_x_reg;
    assign pixel.pixel_y       = pix_y_reg;
    assign pixel.pixel_address = pix_addr_reg;
    assign pixel.out_red       = pix_color_reg[3*COLOR_BITS-1:2*COLOR_BITS];
    assign pixel.out_green     = pix_color_reg[2*COLOR_BITS-1:COLOR_BITS];
    assign pixel.out_blue      = pix_color_reg[COLOR_BITS-1:0];
    assign pixel.write_enable  = pix_we_reg;
    assign pixel.line_done     = pix_done_reg;

endmodule
